>>> sv/lsm_pkg.sv
// ----------------------------------------------------------------------------
// lsm_pkg
// shared constants, operation and status codes, and interface structs for the
// lifo stack with membership test
// ----------------------------------------------------------------------------
package lsm_pkg;

    localparam int DEPTH    = 64;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int COUNT_W  = 7;
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;

    localparam int OUT_FIELDS_W = DATA_W + COUNT_W + 1 + 1 + STATUS_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH        = 3'd0,
        FUNC_POP         = 3'd1,
        FUNC_CLEAR       = 3'd2,
        FUNC_CONTAINS    = 3'd3,
        FUNC_PUSH_UNIQUE = 3'd4,
        FUNC_PUSH_LESS   = 3'd5
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_REJECT   = 2'd1,
        STATUS_OVERFLOW = 2'd2,
        STATUS_EMPTY    = 2'd3
    } status_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } ram_req_t;

    // packed from the top bit down, so top_value lands in the lowest bits
    typedef struct packed {
        status_t            status;
        logic               found;
        logic               is_empty;
        logic [COUNT_W-1:0] count;
        logic [DATA_W-1:0]  top_value;
    } result_t;

endpackage

>>> sv/lsm_ram.sv
// ----------------------------------------------------------------------------
// lsm_ram
// single-port synchronous ram, registered read
// ----------------------------------------------------------------------------
module lsm_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> sv/lsm_ctrl.sv
// ----------------------------------------------------------------------------
// lsm_ctrl
// request sequencer: decodes the operation, drives the stack memory, scans it
// for membership and builds the result
// ----------------------------------------------------------------------------
module lsm_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lsm_pkg::FUNC_W-1:0]    in_func,
    input  logic [lsm_pkg::DATA_W-1:0]    in_value,
    output logic                          res_valid,
    input  logic                          res_ready,
    output lsm_pkg::result_t              res,
    output lsm_pkg::ram_req_t             ram_req,
    input  logic [lsm_pkg::DATA_W-1:0]    ram_rdata
);

    import lsm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_RD,
        S_SCAN,
        S_DONE
    } state_t;

    state_t               state_reg,  state_next;
    logic [CNT_W-1:0]     count_reg,  count_next;
    logic [CNT_W-1:0]     idx_reg,    idx_next;
    logic                 pend_reg,   pend_next;
    logic signed [DATA_W-1:0] top_reg, top_next;
    logic [FUNC_W-1:0]    func_reg,   func_next;
    logic [DATA_W-1:0]    value_reg,  value_next;
    logic                 found_reg,  found_next;
    status_t              status_reg, status_next;

    logic                 hit;
    logic                 full;
    logic [CNT_W-1:0]     cnt_m2;
    logic                 push_go;
    logic [DATA_W-1:0]    push_data;

    assign hit    = pend_reg && (ram_rdata == value_reg);
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign cnt_m2 = count_reg - CNT_W'(2);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        pend_next   = pend_reg;
        top_next    = top_reg;
        func_next   = func_reg;
        value_next  = value_reg;
        found_next  = found_reg;
        status_next = status_reg;
        push_go     = 1'b0;
        push_data   = value_reg;
        ram_req     = '{we: 1'b0, addr: idx_reg[ADDR_W-1:0], wdata: value_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next   = in_func;
                    value_next  = in_value;
                    found_next  = 1'b0;
                    status_next = STATUS_OK;
                    state_next  = S_DONE;
                    push_data   = in_value;
                    unique case (in_func) inside
                        FUNC_PUSH:
                        begin
                            push_go = 1'b1;
                        end
                        FUNC_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                                if (count_reg != CNT_W'(1))
                                begin
                                    // fetch the new top entry
                                    ram_req.addr = cnt_m2[ADDR_W-1:0];
                                    state_next   = S_POP_RD;
                                end
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            count_next = '0;
                        end
                        FUNC_CONTAINS, FUNC_PUSH_UNIQUE:
                        begin
                            idx_next   = '0;
                            pend_next  = 1'b0;
                            state_next = S_SCAN;
                        end
                        FUNC_PUSH_LESS:
                        begin
                            if ((count_reg == '0) || ($signed(in_value) < top_reg))
                            begin
                                push_go = 1'b1;
                            end
                            else
                            begin
                                status_next = STATUS_REJECT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_POP_RD:
            begin
                top_next   = ram_rdata;
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                if (hit || (idx_reg == count_reg))
                begin
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                    if (func_reg == FUNC_PUSH_UNIQUE)
                    begin
                        if (hit)
                        begin
                            found_next  = 1'b1;
                            status_next = STATUS_REJECT;
                        end
                        else
                        begin
                            push_go = 1'b1;
                        end
                    end
                    else
                    begin
                        found_next = hit;
                    end
                end
                else
                begin
                    // one read issued per cycle, compared on the next
                    idx_next  = idx_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (push_go)
        begin
            if (full)
            begin
                status_next = STATUS_OVERFLOW;
            end
            else
            begin
                ram_req    = '{we: 1'b1, addr: count_reg[ADDR_W-1:0], wdata: push_data};
                count_next = count_reg + CNT_W'(1);
                top_next   = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            pend_reg   <= 1'b0;
            top_reg    <= '0;
            func_reg   <= '0;
            value_reg  <= '0;
            found_reg  <= 1'b0;
            status_reg <= STATUS_OK;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            pend_reg   <= pend_next;
            top_reg    <= top_next;
            func_reg   <= func_next;
            value_reg  <= value_next;
            found_reg  <= found_next;
            status_reg <= status_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        res.top_value = (count_reg == '0) ? '0 : top_reg;
        res.count     = COUNT_W'(count_reg);
        res.is_empty  = (count_reg == '0);
        res.found     = found_reg;
        res.status    = status_reg;
    end

endmodule

>>> sv/lifo_stack_with_membership.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_membership
// bounded lifo stack of signed 32-bit values with push, pop, clear,
// membership test, unique push and push-if-less-than-top
// ----------------------------------------------------------------------------
// One request is handled at a time. A push, clear, conditional push or unused
// code goes from acceptance straight to its result; a pop that leaves entries
// behind first reads the new top back from the stack memory. A membership test
// or unique push scans the stored entries through the single memory port, one
// entry per cycle; a hit ends the scan early. The result sits in an output
// register, so the next request is taken while it waits. There is no clearing
// pass after reset.
// ----------------------------------------------------------------------------
module lifo_stack_with_membership (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [lsm_pkg::DATA_W-1:0]         s_axis_tdata,   // value
    input  logic [lsm_pkg::FUNC_W-1:0]         s_axis_tuser,   // func
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // top_value, count, is_empty, found, status, zero pad
    output logic [lsm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    import lsm_pkg::*;

    ram_req_t              ram_req;
    logic [DATA_W-1:0]     ram_rdata;
    logic                  res_valid;
    logic                  res_ready;
    result_t               res;

    logic                  out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    lsm_ram #(
        .WIDTH  (DATA_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

    lsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_func   (s_axis_tuser),
        .in_value  (s_axis_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= {{OUT_PAD_W{1'b0}}, res};
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

>>> sv/lsm_checker.sv
// ----------------------------------------------------------------------------
// lsm_checker
// port-level checks on the result stream of the lifo stack
// ----------------------------------------------------------------------------
module lsm_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [lsm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    import lsm_pkg::*;

    result_t r;

    assign r = m_axis_tdata[OUT_FIELDS_W-1:0];

    // stalled transaction holds its data
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (r.is_empty == (r.count == '0)))
        else $error("empty flag disagrees with count");

    a_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && r.is_empty |-> (r.top_value == '0))
        else $error("nonzero top on empty stack");

    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (r.status == STATUS_OVERFLOW) |-> (r.count == COUNT_W'(DEPTH)))
        else $error("overflow reported while not full");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (r.status == STATUS_EMPTY) |-> r.is_empty && !r.found)
        else $error("pop-on-empty status with entries stored");

endmodule

bind lifo_stack_with_membership lsm_checker u_lsm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
